### hdl/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// nrmc_pkg: shared types and helpers of the rmc sentence decoder
// Field captures handed from the character front end to the sentence back end.
// ----------------------------------------------------------------------------
package nrmc_pkg;

	localparam int FIELD_LEN_MAX = 100;

	localparam logic [1:0] ST_FIX    = 2'd0;
	localparam logic [1:0] ST_NOFIX  = 2'd1;
	localparam logic [1:0] ST_COUNT  = 2'd2;
	localparam logic [1:0] ST_SIMHLD = 2'd3;

	localparam logic [2:0] CFG_SIM_HOLD  = 3'd0;
	localparam logic [2:0] CFG_POS_HOLD  = 3'd1;
	localparam logic [2:0] CFG_FORCE_FIX = 3'd2;
	localparam logic [2:0] CFG_ZONE      = 3'd3;
	localparam logic [2:0] CFG_SPEED     = 3'd4;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// one finished sentence as captured by the front end
	typedef struct packed {
		logic [4:0]       comma_count;
		logic [5:0][7:0]  time_chars;
		logic [7:0]       status_char;
		logic [8:0][7:0]  lat_chars;
		logic [9:0][7:0]  lon_chars;
		logic [6:0]       lat_length;
		logic [6:0]       lon_length;
		logic [1:0]       hemi;
		logic [4:0][7:0]  speed_chars;
		logic [4:0][7:0]  course_chars;
	} sentence_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         utc_hour;
		logic [6:0]         utc_minute;
		logic [6:0]         utc_second;
		logic signed [7:0]  local_hour;
		logic signed [26:0] latitude;
		logic signed [27:0] longitude;
		logic [21:0]        speed;
		logic [13:0]        course;
		logic [7:0]         fix_count;
		logic               rebuild_track;
	} result_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic [3:0] dval(input logic [7:0] c);
		return 4'(c - CH_ZERO);
	endfunction

	// value of a two character pair: the leading digit alone, or both digits when both are digits
	function automatic logic [6:0] pair_val(input logic [7:0] c0, input logic [7:0] c1);
		logic [6:0] v;
		v = 7'd0;
		if (is_dig(c0)) begin
			v = 7'(dval(c0));
			if (is_dig(c1)) v = 7'(v * 7'd10 + 7'(dval(c1)));
		end
		return v;
	endfunction

endpackage

### hdl/nmea_rmc_sentence_decoder.sv
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_decoder: rmc sentence decoder top level
// Character stream in, one decoded fix item out per sentence.
// ----------------------------------------------------------------------------
// One character is taken every cycle unless a finished capture waits on a full queue;
// the item with tlast set closes the sentence and one result item follows, registered in turn
// in the capture register, the queue, the digit decode stage and the accumulate stage. A two-entry queue between
// the character front end and the decode back end lets each side stall alone.
// Write configuration only while no sentence is in flight.
module nmea_rmc_sentence_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, utc_hour, utc_minute, utc_second, local_hour, latitude, longitude,
	// speed, course, fix_count, rebuild_track
	output logic [135:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import nrmc_pkg::*;

	logic              sim_hold_q, pos_hold_q, force_q;
	logic signed [5:0] zone_q;
	logic [15:0]       scale_q;
	logic              cap_valid, cap_ready, q_valid, q_ready;
	sentence_t         cap, qd;
	result_t           res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sim_hold_q <= 1'b0; pos_hold_q <= 1'b0; force_q <= 1'b0;
			zone_q <= '0; scale_q <= 16'd474;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SIM_HOLD:  sim_hold_q <= cfg_data[0];
				CFG_POS_HOLD:  pos_hold_q <= cfg_data[0];
				CFG_FORCE_FIX: force_q <= cfg_data[0];
				CFG_ZONE:      zone_q <= cfg_data[5:0];
				CFG_SPEED:     scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	nrmc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.ch(s_tdata), .last(s_tlast), .cap_valid(cap_valid), .cap_ready(cap_ready), .cap(cap)
	);

	nrmc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(cap_valid), .wr_ready(cap_ready), .wr_data(cap),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(qd)
	);

	nrmc_back u_back (
		.clk(clk), .arst_n(arst_n), .s_valid(q_valid), .s_ready(q_ready), .s(qd),
		.sim_hold(sim_hold_q), .position_hold(pos_hold_q), .force_fix(force_q),
		.zone_hours(zone_q), .speed_scale(scale_q),
		.r_valid(m_tvalid), .r_ready(m_tready), .r(res)
	);

	assign m_tdata = {5'd0, res.rebuild_track, res.fix_count, res.course, res.speed,
		res.longitude, res.latitude, res.local_hour, res.utc_second, res.utc_minute,
		res.utc_hour, res.status};

endmodule

### hdl/nrmc_front.sv
// ----------------------------------------------------------------------------
// nrmc_front: character front end
// Counts commas, stores the field characters and emits one capture per sentence.
// ----------------------------------------------------------------------------
module nrmc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           ch,
	input  logic                 last,
	output logic                 cap_valid,
	input  logic                 cap_ready,
	output nrmc_pkg::sentence_t  cap
);
	import nrmc_pkg::*;

	logic [4:0] comma_q;
	logic [6:0] flen_q;
	sentence_t  st_q;
	sentence_t  nx;
	logic [4:0] cc;
	logic [6:0] pos;
	logic [6:0] flen_n;
	logic       take;

	assign in_ready = !cap_valid || cap_ready;
	assign take     = in_valid && in_ready;
	assign pos      = flen_q;

	always_comb begin
		nx = st_q;
		cc = comma_q;
		flen_n = flen_q;
		if (ch == CH_COMMA) begin
			if (comma_q < 5'd31) cc = 5'(comma_q + 5'd1);
			flen_n = 7'd0;
			case (cc)
				5'd1: nx.time_chars = '0;
				5'd2: nx.status_char = '0;
				5'd3: begin nx.lat_chars = '0; nx.lat_length = '0; end
				5'd4: nx.hemi[0] = 1'b0;
				5'd5: begin nx.lon_chars = '0; nx.lon_length = '0; end
				5'd6: nx.hemi[1] = 1'b0;
				5'd7: nx.speed_chars = '0;
				5'd8: nx.course_chars = '0;
				default: ;
			endcase
		end else begin
			case (comma_q)
				5'd1: if (pos < 7'd6) nx.time_chars[pos[2:0]] = ch;
				5'd2: if (pos == 7'd0) nx.status_char = ch;
				5'd3: if (pos < 7'd9) nx.lat_chars[pos[3:0]] = ch;
				5'd4: if (pos == 7'd0 && ch == CH_S) nx.hemi[0] = 1'b1;
				5'd5: if (pos < 7'd10) nx.lon_chars[pos[3:0]] = ch;
				5'd6: if (pos == 7'd0 && ch == CH_W) nx.hemi[1] = 1'b1;
				5'd7: if (pos < 7'd5) nx.speed_chars[pos[2:0]] = ch;
				5'd8: if (pos < 7'd5) nx.course_chars[pos[2:0]] = ch;
				default: ;
			endcase
			if (flen_q < 7'(FIELD_LEN_MAX - 1)) flen_n = 7'(flen_q + 7'd1);
			if (comma_q == 5'd3) nx.lat_length = flen_n;
			if (comma_q == 5'd5) nx.lon_length = flen_n;
		end
		nx.comma_count = cc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comma_q <= '0;
			flen_q <= '0;
			st_q.status_char <= '0;
			st_q.lat_length <= '0;
			st_q.lon_length <= '0;
			st_q.hemi <= '0;
			cap_valid <= 1'b0;
		end else begin
			if (cap_valid && cap_ready) cap_valid <= 1'b0;
			if (take) begin
				st_q <= nx;
				if (last) begin
					comma_q <= '0;
					flen_q <= '0;
					cap_valid <= 1'b1;
				end else begin
					comma_q <= cc;
					flen_q <= flen_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) cap <= nx;
	end

endmodule

### hdl/nrmc_queue.sv
// ----------------------------------------------------------------------------
// nrmc_queue: two-entry capture queue
// Decouples the character front end from the sentence back end.
// ----------------------------------------------------------------------------
module nrmc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  nrmc_pkg::sentence_t  wr_data,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output nrmc_pkg::sentence_t  rd_data
);
	import nrmc_pkg::*;

	sentence_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= 2'(cnt_q + {1'b0, wr} - {1'b0, rd});
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

### hdl/nrmc_back.sv
// ----------------------------------------------------------------------------
// nrmc_back: sentence back end
// Two-stage decode of a captured sentence into the result item.
// ----------------------------------------------------------------------------
module nrmc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_valid,
	output logic                 s_ready,
	input  nrmc_pkg::sentence_t  s,
	input  logic                 sim_hold,
	input  logic                 position_hold,
	input  logic                 force_fix,
	input  logic signed [5:0]    zone_hours,
	input  logic [15:0]          speed_scale,
	output logic                 r_valid,
	input  logic                 r_ready,
	output nrmc_pkg::result_t    r
);
	import nrmc_pkg::*;

	// stage 1: digit decode
	logic        v_s1;
	logic [1:0]  status_s1;
	logic [6:0]  h_s1, m_s1, sec_s1;
	logic [13:0] crs_s1;
	logic        lat_neg_s1, lon_neg_s1;
	logic [26:0] lat_mag_s1;
	logic [29:0] lon_mag_s1;
	logic        adv1, adv2;

	logic [1:0]  status_c;
	logic [6:0]  h_c, m_c, sec_c;
	logic [7:0]  lp [9];
	logic [7:0]  op [10];
	logic [26:0] lat_c;
	logic [29:0] lon_c;

	function automatic logic [13:0] tenths(input logic [4:0][7:0] c);
		logic [9:0] v;
		logic ok;
		v = 10'd0;
		ok = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (ok && is_dig(c[i])) v = 10'(v * 10'd10 + 10'(dval(c[i])));
			else ok = 1'b0;
		end
		return 14'(v * 14'd10 + ((ok && is_dig(c[4])) ? 14'(dval(c[4])) : 14'd0));
	endfunction

	// three degree digits reach about 600 million, wider than the longitude field
	function automatic logic [29:0] coord(input logic [7:0] p0, input logic [7:0] p1,
		input logic [7:0] p2, input logic [7:0] a0, input logic [7:0] a1,
		input logic [7:0] f0, input logic [7:0] f1, input logic [7:0] f2,
		input logic [7:0] f3, input logic three);
		logic [9:0] d;
		logic [6:0] mn;
		logic [13:0] fr;
		logic [29:0] v;
		d = 10'd0;
		if (is_dig(p0)) begin
			d = 10'(dval(p0));
			if (is_dig(p1)) begin
				d = 10'(d * 10'd10 + 10'(dval(p1)));
				if (three && is_dig(p2)) d = 10'(d * 10'd10 + 10'(dval(p2)));
			end
		end
		mn = pair_val(a0, a1);
		fr = 14'd0;
		if (is_dig(a0) && is_dig(a1) && is_dig(f0)) begin
			fr = 14'(dval(f0)) * 14'd1000;
			if (is_dig(f1)) begin
				fr = 14'(fr + 14'(dval(f1)) * 14'd100);
				if (is_dig(f2)) begin
					fr = 14'(fr + 14'(dval(f2)) * 14'd10);
					if (is_dig(f3)) fr = 14'(fr + 14'(dval(f3)));
				end
			end
		end
		v = 30'(d) * 30'd600000 + 30'(mn) * 30'd10000 + 30'(fr);
		return v;
	endfunction

	always_comb begin
		// zero padding of short coordinate fields
		for (int i = 0; i < 9; i++) begin
			if (s.lat_length < 7'd8)
				lp[i] = (7'(i) < 7'd9 - s.lat_length) ? CH_ZERO
					: s.lat_chars[4'(7'(i) + s.lat_length - 7'd9)];
			else lp[i] = s.lat_chars[i];
		end
		for (int i = 0; i < 10; i++) begin
			if (s.lon_length < 7'd9)
				op[i] = (7'(i) < 7'd10 - s.lon_length) ? CH_ZERO
					: s.lon_chars[4'(7'(i) + s.lon_length - 7'd10)];
			else op[i] = s.lon_chars[i];
		end
		lat_c = 27'(coord(lp[0], lp[1], lp[1], lp[2], lp[3], lp[5], lp[6], lp[7], lp[8], 1'b0));
		lon_c = coord(op[0], op[1], op[2], op[3], op[4], op[6], op[7], op[8], op[9], 1'b1);
		h_c = '0; m_c = '0; sec_c = '0;
		if (sim_hold && !position_hold) status_c = ST_SIMHLD;
		else if (s.comma_count != 5'd11 && s.comma_count != 5'd12) status_c = ST_COUNT;
		else begin
			h_c = pair_val(s.time_chars[0], s.time_chars[1]);
			if (is_dig(s.time_chars[0]) && is_dig(s.time_chars[1])) begin
				m_c = pair_val(s.time_chars[2], s.time_chars[3]);
				if (is_dig(s.time_chars[2]) && is_dig(s.time_chars[3]))
					sec_c = pair_val(s.time_chars[4], s.time_chars[5]);
			end
			status_c = (s.status_char != CH_A && !force_fix) ? ST_NOFIX : ST_FIX;
		end
	end

	// stage 2 state
	logic [7:0]         cnt_q;
	logic signed [7:0]  hl_q;
	logic signed [26:0] lat_q;
	logic signed [27:0] lon_q;
	logic [7:0]         cnt_n;
	logic               reb;
	logic signed [7:0]  hl_n;
	logic signed [26:0] lat_n;
	logic signed [27:0] lon_n;
	logic [29:0]        prod;

	assign adv2 = v_s1 && (!r_valid || r_ready);
	assign s_ready = !v_s1 || adv2;
	assign adv1 = s_valid && s_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (s_ready) v_s1 <= s_valid;
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			status_s1 <= status_c;
			h_s1 <= h_c; m_s1 <= m_c; sec_s1 <= sec_c;
			crs_s1 <= tenths(s.course_chars);
			lat_neg_s1 <= s.hemi[0];
			lon_neg_s1 <= s.hemi[1];
			lat_mag_s1 <= lat_c;
			lon_mag_s1 <= lon_c;
		end
	end

	logic [13:0] spd_t;
	always_ff @(posedge clk) begin
		if (adv1) spd_t <= tenths(s.speed_chars);
	end

	always_comb begin
		cnt_n = cnt_q; reb = 1'b0; hl_n = hl_q; lat_n = lat_q; lon_n = lon_q;
		prod = 30'(spd_t) * 30'(speed_scale);
		if (status_s1 == ST_NOFIX) cnt_n = '0;
		else if (status_s1 == ST_FIX) begin
			if (cnt_q != 8'd255) begin
				cnt_n = 8'(cnt_q + 8'd1);
				reb = cnt_n == 8'd3;
			end
			if (!position_hold) begin
				if (lat_mag_s1 <= 27'd54000000)
					lat_n = lat_neg_s1 ? -$signed(lat_mag_s1) : $signed(lat_mag_s1);
				if (lon_mag_s1 <= 30'd108000000)
					lon_n = lon_neg_s1 ? -$signed(lon_mag_s1[27:0])
						: $signed(lon_mag_s1[27:0]);
			end
			hl_n = 8'($signed({1'b0, h_s1})) + 8'(zone_hours);
			if (hl_n > 8'sd23) hl_n = 8'(hl_n - 8'sd24);
			if (hl_n < 8'sd0) hl_n = 8'(hl_n + 8'sd24);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; hl_q <= '0; lat_q <= '0; lon_q <= '0; r_valid <= 1'b0;
		end else begin
			if (r_valid && r_ready) r_valid <= 1'b0;
			if (adv2) begin
				cnt_q <= cnt_n; hl_q <= hl_n; lat_q <= lat_n; lon_q <= lon_n;
				r_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			r.status <= status_s1;
			r.utc_hour <= h_s1;
			r.utc_minute <= m_s1;
			r.utc_second <= sec_s1;
			r.local_hour <= hl_n;
			r.latitude <= lat_n;
			r.longitude <= lon_n;
			r.speed <= (status_s1 == ST_FIX) ? 22'(prod >> 8) : '0;
			r.course <= (status_s1 == ST_FIX) ? crs_s1 : '0;
			r.fix_count <= cnt_n;
			r.rebuild_track <= reb;
		end
	end

endmodule
